@@ rtl/rws_pkg.sv @@
`default_nettype none
package rws_pkg;

  // Field widths of the command and result words
  localparam int unsigned OP_W   = 2;
  localparam int unsigned FIT_W  = 24;  // UQ16.8 fitness
  localparam int unsigned RND_W  = 16;  // UQ0.16 random fraction
  localparam int unsigned SEL_W  = 6;   // index fields
  localparam int unsigned SUM_W  = 30;  // prefix sums and total, units of 2^-8

  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Saturation ceiling of the running total
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_DRAW  = 2'd2
  } op_e;

  // Command word
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [FIT_W-1:0] fitness;
    logic [RND_W-1:0] random_fraction;
    logic [SEL_W-1:0] uniform_index;
  } rws_in_t;

  // Result word
  typedef struct packed {
    logic [SEL_W-1:0] selected;
    logic             used_uniform;
    logic             no_entries;
  } rws_out_t;

  // Search token walking along the cell chain
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] target;
  } rws_tok_t;

endpackage
`default_nettype wire

@@ rtl/roulette_wheel_selector_unit.sv @@
`default_nettype none
// Roulette-wheel selector. Words are taken when start_i is high and busy_o
// is low. Clear and load leave busy_o low and give no result. A draw with
// no entries or a zero total gives its result word in the cycle after
// acceptance. Otherwise the scaled target is formed in the acceptance
// cycle and a search token walks the row of slot cells, one cell per
// cycle, stopping at the chosen index k: busy_o stays high while the token
// walks and valid_o pulses for one cycle right after. The walk along the
// cell row sets the draw time, so it grows with the chosen index. valid_o
// marks each result word for exactly one cycle; it must be taken then.
module roulette_wheel_selector_unit #(
  parameter int unsigned MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire rws_pkg::rws_in_t item_i,
  output logic             busy_o,
  output logic             valid_o,
  output rws_pkg::rws_out_t result_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = rws_pkg::SUM_W;
  localparam int unsigned FIT_W = rws_pkg::FIT_W;
  localparam int unsigned RND_W = rws_pkg::RND_W;
  localparam int unsigned SEL_W = rws_pkg::SEL_W;
  localparam int unsigned ADD_W = ((SUM_W > FIT_W) ? SUM_W : FIT_W) + 1;
  localparam int unsigned UNI_W = (CNT_W > SEL_W) ? CNT_W : SEL_W;
  localparam int unsigned PRD_W = SUM_W + RND_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SEARCH
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      count_q;
  logic [SUM_W-1:0]      total_q;
  logic [SUM_W-1:0]      target_q;
  logic [IDX_W-1:0]      pos_q;
  logic                  valid_q;
  rws_pkg::rws_out_t     res_q;

  logic                  accept;
  logic [ADD_W-1:0]      sum_ext;
  logic [SUM_W-1:0]      sum_sat;
  logic [PRD_W-1:0]      product;
  logic [UNI_W-1:0]      uni_u;
  logic [UNI_W-1:0]      uni_last;
  logic [UNI_W-1:0]      uni_sel;
  logic                  wr_en;

  rws_pkg::rws_tok_t     tok_in;
  rws_pkg::rws_tok_t     tok_chain [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hits;
  logic                  hit_any;

  assign accept = start_i && (state_q == ST_IDLE);

  // Saturating accumulate of the new fitness
  assign sum_ext = ADD_W'(total_q) + ADD_W'(item_i.fitness);
  assign sum_sat = (sum_ext > ADD_W'(rws_pkg::SUM_MAX)) ? rws_pkg::SUM_MAX
                                                         : sum_ext[SUM_W-1:0];

  assign wr_en = accept && (item_i.operation == rws_pkg::OP_LOAD) && (count_q < CNT_FULL);

  // Scaled target: fraction times total, integer part kept
  assign product = PRD_W'(item_i.random_fraction) * PRD_W'(total_q);

  // Uniform fallback index, clamped to the last entry
  assign uni_u    = UNI_W'(item_i.uniform_index);
  assign uni_last = UNI_W'(count_q) - UNI_W'(1);
  assign uni_sel  = (uni_u < uni_last) ? uni_u : uni_last;

  // Token injection into the first cell
  always_comb begin
    tok_in.vld    = (state_q == ST_LAUNCH);
    tok_in.target = target_q;
  end

  assign tok_chain[0] = tok_in;

  // Row of slot cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    rws_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_idx_i  (count_q[IDX_W-1:0]),
      .wr_data_i (sum_sat),
      .count_i   (count_q),
      .tok_i     (tok_chain[i]),
      .tok_o     (tok_chain[i+1]),
      .hit_o     (hits[i])
    );
  end

  // Only one token is ever in flight, so at most one hit is set
  assign hit_any = |hits;

  // Control, round state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      target_q <= '0;
      pos_q    <= '0;
      valid_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (item_i.operation)
              rws_pkg::OP_CLEAR: begin
                count_q <= '0;
                total_q <= '0;
              end
              rws_pkg::OP_LOAD: begin
                if (count_q < CNT_FULL) begin
                  total_q <= sum_sat;
                  count_q <= count_q + CNT_W'(1);
                end
              end
              rws_pkg::OP_DRAW: begin
                if (count_q == '0) begin
                  valid_q               <= 1'b1;
                  res_q.selected        <= '0;
                  res_q.used_uniform    <= 1'b0;
                  res_q.no_entries      <= 1'b1;
                end else if (total_q == '0) begin
                  valid_q               <= 1'b1;
                  res_q.selected        <= uni_sel[SEL_W-1:0];
                  res_q.used_uniform    <= 1'b1;
                  res_q.no_entries      <= 1'b0;
                end else begin
                  target_q <= product[RND_W +: SUM_W];
                  state_q  <= ST_LAUNCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LAUNCH: begin
          pos_q   <= '0;
          state_q <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (hit_any) begin
            valid_q            <= 1'b1;
            res_q.selected     <= SEL_W'(pos_q);
            res_q.used_uniform <= 1'b0;
            res_q.no_entries   <= 1'b0;
            state_q            <= ST_IDLE;
          end else begin
            pos_q <= pos_q + IDX_W'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

@@ rtl/rws_cell.sv @@
`default_nettype none
// One wheel slot: holds a prefix sum and tests the passing search token.
module rws_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 6,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [IDX_W-1:0]            wr_idx_i,
  input  wire logic [rws_pkg::SUM_W-1:0]   wr_data_i,
  input  wire logic [CNT_W-1:0]            count_i,
  input  wire rws_pkg::rws_tok_t           tok_i,
  output rws_pkg::rws_tok_t                tok_o,
  output logic                             hit_o
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

  logic [rws_pkg::SUM_W-1:0] prefix_q;
  rws_pkg::rws_tok_t         tok_q;
  logic                      is_last;

  // Prefix sum store, written once per load
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == MY_IDX)) begin
      prefix_q <= wr_data_i;
    end
  end

  // Token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.vld    <= 1'b0;
      tok_q.target <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // Stop on first prefix above target, or at the last loaded slot
  assign is_last = (count_i == MY_NEXT);
  assign hit_o   = tok_q.vld && ((prefix_q > tok_q.target) || is_last);

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_q.vld && !hit_o;
  end

endmodule
`default_nettype wire
